[design/fam_pkg.sv]
// ----------------------------------------------------------------------------
// fam_pkg: shared types and constants for the GF(2^255-19) arithmetic unit
// Holds the operation codes, the field prime and the pipeline control word.
// ----------------------------------------------------------------------------
package fam_pkg;

  typedef enum logic [1:0] {
    KIND_MUL  = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_SUB  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  localparam int FW = 255;      // field element width
  localparam int AW = 257;      // add/subtract intermediate width
  localparam int SW = 300;      // folded product sum width
  localparam int TW = 256;      // width after the first fold

  localparam logic [FW-1:0] PRIME  = {{(FW-5){1'b1}}, 5'b01101};
  localparam logic [AW-1:0] TWO_P  = {1'b0, {(TW-6){1'b1}}, 6'b011010};
  localparam logic [5:0]    FOLD38 = 6'd38;
  localparam logic [4:0]    FOLD19 = 5'd19;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctl_t;

endpackage

[design/field_arith_mod_2p255m19.sv]
// ----------------------------------------------------------------------------
// field_arith_mod_2p255m19: multiply, add and subtract modulo 2^255-19
// Eight-stage pipeline returning canonical results in [0, p).
// ----------------------------------------------------------------------------
// A word is taken at every clock edge where start is high; busy is always low,
// so one word may be issued every cycle. Its result appears on r_w0..r_w3 with
// done high for one cycle, in issue order. The receiver cannot hold
// results off. The latency is set by the multiply path: an input register,
// 64 parallel 32x32 partial products, column sums, the fold of the upper
// half by 38, one wide carry add, two folds by 19 and a final conditional
// subtraction of p. Add and subtract ride the same pipeline and join it at
// the wide add. Kind 3 returns zero.
module field_arith_mod_2p255m19 import fam_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] a_w0,
  input  logic [63:0] a_w1,
  input  logic [63:0] a_w2,
  input  logic [63:0] a_w3,
  input  logic [63:0] b_w0,
  input  logic [63:0] b_w1,
  input  logic [63:0] b_w2,
  input  logic [63:0] b_w3,
  output logic        done,
  output logic [63:0] r_w0,
  output logic [63:0] r_w1,
  output logic [63:0] r_w2,
  output logic [62:0] r_w3
);

  ctl_t          ctl1, ctl2, ctl3, ctl4, ctl5;
  logic [FW-1:0] a1, b1;
  logic [255:0]  a_ext, b_ext;
  logic [63:0]   prod [8][8];
  logic [AW-1:0] as2, as3, as4;
  logic [66:0]   col [15];
  logic [66:0]   col_next [15];
  logic [73:0]   fold [8];
  logic [319:0]  v0, v1, v2, vsum;
  logic [SW-1:0] sum5;

  assign busy = 1'b0;

  assign a_ext = {1'b0, a1};
  assign b_ext = {1'b0, b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
      ctl5 <= '0;
    end else begin
      ctl1 <= '{valid: start && !busy, kind: kind_t'(kind)};
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
    end
  end

  always_ff @(posedge clk) begin
    a1 <= {a_w3[62:0], a_w2, a_w1, a_w0};
    b1 <= {b_w3[62:0], b_w2, b_w1, b_w0};
  end

  // Partial products, one 32x32 multiplier each.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        prod[i][j] <= 64'(a_ext[32*i +: 32]) * 64'(b_ext[32*j +: 32]);
      end
    end
    if (ctl1.kind == KIND_SUB) begin
      as2 <= AW'(a1) + TWO_P - AW'(b1);
    end else begin
      as2 <= AW'(a1) + AW'(b1);
    end
  end

  always_comb begin
    for (int k = 0; k < 15; k++) begin
      col_next[k] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        col_next[i+j] = col_next[i+j] + 67'(prod[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    col <= col_next;
    as3 <= as2;
  end

  // Columns at 2^256 and above fold back with 2^256 = 38 (mod p).
  always_ff @(posedge clk) begin
    for (int k = 0; k < 7; k++) begin
      fold[k] <= 74'(col[k]) + 74'(col[k+8]) * 74'(FOLD38);
    end
    fold[7] <= 74'(col[7]);
    as4 <= as3;
  end

  always_comb begin
    v0 = '0;
    v1 = '0;
    v2 = '0;
    for (int k = 0; k < 8; k++) begin
      v0[32*k +: 32]     = fold[k][31:0];
      v1[32*(k+1) +: 32] = fold[k][63:32];
      v2[32*(k+2) +: 32] = {22'b0, fold[k][73:64]};
    end
    vsum = v0 + v1 + v2;
  end

  always_ff @(posedge clk) begin
    if (ctl4.kind == KIND_MUL) begin
      sum5 <= vsum[SW-1:0];
    end else begin
      sum5 <= SW'(as4);
    end
  end

  fam_reduce u_reduce (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl5),
    .sum_in (sum5),
    .done   (done),
    .r_w0   (r_w0),
    .r_w1   (r_w1),
    .r_w2   (r_w2),
    .r_w3   (r_w3)
  );

endmodule

[design/fam_reduce.sv]
// ----------------------------------------------------------------------------
// fam_reduce: final reduction stages
// Folds a 300-bit sum twice with 2^255 = 19 (mod p) and conditionally subtracts p.
// ----------------------------------------------------------------------------
module fam_reduce import fam_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          ctl_in,
  input  logic [SW-1:0] sum_in,
  output logic          done,
  output logic [63:0]   r_w0,
  output logic [63:0]   r_w1,
  output logic [63:0]   r_w2,
  output logic [62:0]   r_w3
);

  ctl_t          ctl6, ctl7;
  logic [TW-1:0] t6;
  logic [TW-1:0] u7;
  logic [TW-1:0] u_next;
  logic [TW-1:0] w_sum;
  logic [FW-1:0] res;

  // The upper bits weigh 2^255 each, which is 19 modulo p.
  always_ff @(posedge clk) begin
    t6 <= TW'(sum_in[FW-1:0]) + TW'(sum_in[SW-1:FW] * 50'(FOLD19));
    u7 <= u_next;
  end

  assign u_next = TW'(t6[FW-1:0]) + (t6[TW-1] ? TW'(FOLD19) : TW'(0));

  // U is below 2p, so U >= p exactly when U + 19 reaches 2^255.
  assign w_sum = u7 + TW'(FOLD19);
  always_comb begin
    if (ctl7.kind == KIND_NONE) begin
      res = '0;
    end else if (w_sum[TW-1]) begin
      res = w_sum[FW-1:0];
    end else begin
      res = u7[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl6 <= '0;
      ctl7 <= '0;
      done <= 1'b0;
    end else begin
      ctl6 <= ctl_in;
      ctl7 <= ctl6;
      done <= ctl7.valid;
    end
  end

  always_ff @(posedge clk) begin
    r_w0 <= res[63:0];
    r_w1 <= res[127:64];
    r_w2 <= res[191:128];
    r_w3 <= res[254:192];
  end

  a_canonical: assert property (@(posedge clk) disable iff (rst)
    done |-> ({r_w3, r_w2, r_w1, r_w0} < PRIME))
    else $error("result not below p");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl6.valid, 2))
    else $error("result word without a matching item");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result word right after reset");

endmodule
